// ===== hw/rtl/lpm_pkg.sv =====
// ---------------------------------------------------------------------------
// lpm_pkg: shared types and constants
// Request/response beat types, status codes, functions and sequencer states.
// ---------------------------------------------------------------------------
package lpm_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_PREFIX     = 128;
    localparam int V4_MAX_LEN     = 32;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_SPARE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_LEN   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic        is_v6;
        logic [7:0]  prefix_len;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_value;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    // Mask with the top len bits set, len 0..128, over a 128-bit word.
    function automatic logic [127:0] prefix_mask(input logic [7:0] len);
        logic [127:0] m;
        m = '1;
        if (len == 8'd0)
            prefix_mask = '0;
        else if (len >= 8'd128)
            prefix_mask = m;
        else
            prefix_mask = ~(m >> len);
    endfunction

endpackage

// ===== hw/rtl/longest_prefix_match_table_unit.sv =====
// ---------------------------------------------------------------------------
// longest_prefix_match_table_unit: IPv4/IPv6 longest-prefix route table
// Lookup, insert and remove over a slot RAM scanned at most once per request.
// ---------------------------------------------------------------------------
// One request at a time. After reset the block walks the route RAM once and
// clears the valid bit of every slot, one slot per cycle, holding in_ready
// low until the walk is done. Every lookup, and every insert or remove with
// a nonzero, legal prefix length, then reads all ENTRIES slots at one slot
// per cycle; insert and remove then write the slot back in S_WRITE before
// setting the response beat. Default-route writes and insert or remove
// length errors respond from S_DONE without a scan. The response beat sits
// in an output register and the next request is taken the cycle after that
// beat is consumed, so no new request is taken while a response waits.
module longest_prefix_match_table_unit #(
    parameter int ENTRIES    = lpm_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = lpm_pkg::VALUE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lpm_pkg::req_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output lpm_pkg::rsp_t  out_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    // Slot word: valid, family, length, prefix hi/lo, value.
    localparam int SW = 1 + 1 + 8 + 128 + VALUE_BITS;

    lpm_pkg::state_t state_reg, state_next;
    lpm_pkg::req_t   req_reg;
    logic [127:0]    addr_reg;   // family-masked address
    logic [127:0]    pfx_reg;    // address cut to prefix_len
    logic [CW-1:0]   rd_cnt_reg; // next slot to read
    logic [AW-1:0]   clr_cnt_reg; // next slot to clear after reset
    logic [AW-1:0]   cmp_idx_reg;
    logic            cmp_vld_reg;
    logic            def_valid_reg;
    logic [VALUE_BITS-1:0] def_value_reg;
    logic            match_hit_reg;
    logic [AW-1:0]   match_idx_reg;
    logic            free_hit_reg;
    logic [AW-1:0]   free_idx_reg;
    logic            best_hit_reg;
    logic [7:0]      best_len_reg;
    logic [VALUE_BITS-1:0] best_val_reg;
    logic            out_valid_reg;
    lpm_pkg::rsp_t   out_data_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [SW-1:0]   ram_wdata, ram_rdata;

    logic            s_vld;
    logic            s_fam;
    logic [7:0]      s_len;
    logic [127:0]    s_pfx;
    logic [VALUE_BITS-1:0] s_val;
    logic [VALUE_BITS-1:0] in_val;
    logic            bad_len, upd_op, is_ins;
    logic            accept;
    logic            scan_last;
    logic            lk_match, ex_match;

    assign {s_vld, s_fam, s_len, s_pfx, s_val} = ram_rdata;
    assign in_val = VALUE_BITS'(req_reg.value);

    lpm_ram #(
        .WIDTH (SW),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == lpm_pkg::S_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_ins  = (req_reg.func == lpm_pkg::FUNC_INSERT);
    assign upd_op  = is_ins || (req_reg.func == lpm_pkg::FUNC_REMOVE);
    assign bad_len = (req_reg.prefix_len > 8'(lpm_pkg::MAX_PREFIX)) ||
                     (!req_reg.is_v6 && req_reg.prefix_len > 8'(lpm_pkg::V4_MAX_LEN));
    assign scan_last = cmp_vld_reg && (cmp_idx_reg == AW'(ENTRIES - 1));

    // Compare the slot just read against the request.
    assign ex_match = s_vld && (s_fam == req_reg.is_v6) &&
                      (s_len == req_reg.prefix_len) && (s_pfx == pfx_reg);
    assign lk_match = s_vld && (s_fam == req_reg.is_v6) &&
                      ((addr_reg & lpm_pkg::prefix_mask(s_len)) == s_pfx);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = rd_cnt_reg[AW-1:0];
        ram_wdata = {is_ins, req_reg.is_v6, req_reg.prefix_len, pfx_reg, in_val};
        unique case (state_reg)
            lpm_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            lpm_pkg::S_WRITE:
            begin
                // Insert rewrites the whole slot; remove writes it back with
                // the valid bit low.
                ram_we   = match_hit_reg || (is_ins && free_hit_reg);
                ram_addr = match_hit_reg ? match_idx_reg : free_idx_reg;
            end
            default:
                ;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpm_pkg::S_CLEAR:
                if (clr_cnt_reg == AW'(ENTRIES - 1))
                    state_next = lpm_pkg::S_IDLE;
            lpm_pkg::S_IDLE:
                if (accept)
                    state_next = lpm_pkg::S_DONE;
            lpm_pkg::S_DONE:
                // First cycle after accept: decide whether a scan is needed.
                if (!(upd_op && (bad_len || req_reg.prefix_len == 8'd0)))
                    state_next = lpm_pkg::S_SCAN;
                else
                    state_next = lpm_pkg::S_IDLE;
            lpm_pkg::S_SCAN:
                if (scan_last)
                    state_next = upd_op ? lpm_pkg::S_WRITE : lpm_pkg::S_IDLE;
            lpm_pkg::S_WRITE:
                state_next = lpm_pkg::S_IDLE;
            default:
                state_next = lpm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpm_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            def_valid_reg <= 1'b0;
            def_value_reg <= '0;
            out_valid_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            cmp_vld_reg <= (state_reg == lpm_pkg::S_SCAN) &&
                           (rd_cnt_reg < CW'(ENTRIES));
            unique case (state_reg)
                lpm_pkg::S_CLEAR:
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                lpm_pkg::S_DONE:
                    if (upd_op && (bad_len || req_reg.prefix_len == 8'd0))
                    begin
                        out_valid_reg <= 1'b1;
                        if (!bad_len)
                        begin
                            def_valid_reg <= is_ins;
                            def_value_reg <= is_ins ? in_val : '0;
                        end
                    end
                lpm_pkg::S_SCAN:
                    if (scan_last && !upd_op)
                        out_valid_reg <= 1'b1;
                lpm_pkg::S_WRITE:
                    out_valid_reg <= 1'b1;
                default:
                    ;
            endcase
        end
    end

    // Datapath: request capture, scan trackers, response formation.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= in_data;
            addr_reg <= in_data.is_v6 ? {in_data.addr_hi, in_data.addr_lo} :
                                        {in_data.addr_hi[63:32], 96'd0};
        end
        unique case (state_reg)
            lpm_pkg::S_DONE:
            begin
                pfx_reg       <= addr_reg & lpm_pkg::prefix_mask(req_reg.prefix_len);
                rd_cnt_reg    <= '0;
                match_hit_reg <= 1'b0;
                free_hit_reg  <= 1'b0;
                best_hit_reg  <= 1'b0;
                best_len_reg  <= '0;
                best_val_reg  <= '0;
                out_data_reg.status       <= bad_len ? lpm_pkg::ST_BAD_LEN : lpm_pkg::ST_OK;
                out_data_reg.result_value <= '0;
            end
            lpm_pkg::S_SCAN:
            begin
                if (rd_cnt_reg < CW'(ENTRIES))
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                cmp_idx_reg <= rd_cnt_reg[AW-1:0];
                if (cmp_vld_reg)
                begin
                    if (!s_vld && !free_hit_reg)
                    begin
                        free_hit_reg <= 1'b1;
                        free_idx_reg <= cmp_idx_reg;
                    end
                    if (ex_match && !match_hit_reg)
                    begin
                        match_hit_reg <= 1'b1;
                        match_idx_reg <= cmp_idx_reg;
                    end
                    if (lk_match && (!best_hit_reg || s_len > best_len_reg))
                    begin
                        best_hit_reg <= 1'b1;
                        best_len_reg <= s_len;
                        best_val_reg <= s_val;
                    end
                end
                if (scan_last && !upd_op)
                begin
                    // Fold in the final slot before picking the winner.
                    if (lk_match && (!best_hit_reg || s_len > best_len_reg))
                    begin
                        out_data_reg.status       <= lpm_pkg::ST_OK;
                        out_data_reg.result_value <= 32'(s_val);
                    end
                    else if (best_hit_reg)
                    begin
                        out_data_reg.status       <= lpm_pkg::ST_OK;
                        out_data_reg.result_value <= 32'(best_val_reg);
                    end
                    else if (def_valid_reg)
                    begin
                        out_data_reg.status       <= lpm_pkg::ST_OK;
                        out_data_reg.result_value <= 32'(def_value_reg);
                    end
                    else
                        out_data_reg.status <= lpm_pkg::ST_NOT_FOUND;
                end
            end
            lpm_pkg::S_WRITE:
                if (is_ins)
                    out_data_reg.status <= (match_hit_reg || free_hit_reg) ?
                                           lpm_pkg::ST_OK : lpm_pkg::ST_FULL;
                else
                    out_data_reg.status <= match_hit_reg ?
                                           lpm_pkg::ST_OK : lpm_pkg::ST_NOT_FOUND;
            default:
                ;
        endcase
    end

endmodule

// ===== hw/rtl/lpm_ram.sv =====
// ---------------------------------------------------------------------------
// lpm_ram: generic single-port synchronous RAM
// One read per cycle, plus a write when we is high; read data registered.
// ---------------------------------------------------------------------------
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/tb_longest_prefix_match_table_unit.sv =====
// ---------------------------------------------------------------------------
// tb_longest_prefix_match_table_unit: route table request/response check
// Drives lookup, insert and remove beats with bursty valid and a stalling
// receiver, predicts every response from a behavioral copy of the table and
// compares each response beat with the oldest predicted one.
// ---------------------------------------------------------------------------
module tb_longest_prefix_match_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS    = 64;
    localparam int N_RANDOM   = 1650;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_WAIT = 200;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    lpm_pkg::req_t in_data;
    logic out_valid;
    logic out_ready;
    lpm_pkg::rsp_t out_data;

    longest_prefix_match_table_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Behavioral route table
    logic         rt_valid [N_SLOTS];
    logic         rt_v6    [N_SLOTS];
    logic [7:0]   rt_len   [N_SLOTS];
    logic [127:0] rt_pfx   [N_SLOTS];
    logic [31:0]  rt_val   [N_SLOTS];
    logic         dflt_valid;
    logic [31:0]  dflt_val;

    lpm_pkg::rsp_t rsp_pending [$];
    int   errors;
    int   cycles;

    // Pool of prefixes already used, so later beats hit existing routes.
    lpm_pkg::req_t route_pool [$];

    function automatic logic [127:0] len_mask(input int len);
        logic [127:0] m;
        m = '1;
        if (len == 0)
            return '0;
        if (len >= 128)
            return m;
        return ~(m >> len);
    endfunction

    // Compute the response to one request and update the table.
    function automatic lpm_pkg::rsp_t route_table_step(input lpm_pkg::req_t r);
        lpm_pkg::rsp_t o;
        logic [127:0]  a;
        logic [127:0]  p;
        int            len;
        int            hit;
        int            free_i;
        int            best;
        int            best_len;
        o.status = lpm_pkg::ST_OK;
        o.result_value = '0;
        len = r.prefix_len;
        a = {r.addr_hi, r.addr_lo};
        if (!r.is_v6)
            a = {r.addr_hi[63:32], 96'd0};
        if (r.func == lpm_pkg::FUNC_INSERT || r.func == lpm_pkg::FUNC_REMOVE)
        begin
            if (len > lpm_pkg::MAX_PREFIX || (!r.is_v6 && len > lpm_pkg::V4_MAX_LEN))
            begin
                o.status = lpm_pkg::ST_BAD_LEN;
            end
            else if (len == 0)
            begin
                dflt_valid = (r.func == lpm_pkg::FUNC_INSERT);
                dflt_val = (r.func == lpm_pkg::FUNC_INSERT) ? r.value : '0;
            end
            else
            begin
                p = a & len_mask(len);
                hit = -1;
                free_i = -1;
                for (int i = 0; i < N_SLOTS; i++)
                begin
                    if (!rt_valid[i])
                    begin
                        if (free_i < 0)
                            free_i = i;
                    end
                    else if (hit < 0 && rt_v6[i] == r.is_v6 && rt_len[i] == 8'(len)
                             && rt_pfx[i] == p)
                    begin
                        hit = i;
                    end
                end
                if (r.func == lpm_pkg::FUNC_INSERT)
                begin
                    if (hit >= 0)
                    begin
                        rt_val[hit] = r.value;
                    end
                    else if (free_i >= 0)
                    begin
                        rt_valid[free_i] = 1'b1;
                        rt_v6[free_i] = r.is_v6;
                        rt_len[free_i] = 8'(len);
                        rt_pfx[free_i] = p;
                        rt_val[free_i] = r.value;
                    end
                    else
                    begin
                        o.status = lpm_pkg::ST_FULL;
                    end
                end
                else if (hit >= 0)
                begin
                    rt_valid[hit] = 1'b0;
                end
                else
                begin
                    o.status = lpm_pkg::ST_NOT_FOUND;
                end
            end
        end
        else
        begin
            // lookup, and the spare code which behaves as one
            best = -1;
            best_len = 0;
            for (int i = 0; i < N_SLOTS; i++)
            begin
                if (rt_valid[i] && rt_v6[i] == r.is_v6
                    && (a & len_mask(rt_len[i])) == rt_pfx[i]
                    && (best < 0 || rt_len[i] > best_len))
                begin
                    best = i;
                    best_len = rt_len[i];
                end
            end
            if (best >= 0)
                o.result_value = rt_val[best];
            else if (dflt_valid)
                o.result_value = dflt_val;
            else
                o.status = lpm_pkg::ST_NOT_FOUND;
        end
        return o;
    endfunction

    // Directed table: fixed expectation where obvious, else predictor only.
    typedef struct {
        lpm_pkg::req_t r;
        logic          fixed;
        lpm_pkg::rsp_t want;
    } vec_t;

    function automatic lpm_pkg::req_t mk(input lpm_pkg::func_t f, input logic [63:0] hi,
                                         input logic [63:0] lo, input logic v6,
                                         input logic [7:0] len, input logic [31:0] v);
        lpm_pkg::req_t r;
        r.func = f;
        r.addr_hi = hi;
        r.addr_lo = lo;
        r.is_v6 = v6;
        r.prefix_len = len;
        r.value = v;
        return r;
    endfunction

    function automatic lpm_pkg::rsp_t rs(input lpm_pkg::status_t s, input logic [31:0] v);
        lpm_pkg::rsp_t o;
        o.status = s;
        o.result_value = v;
        return o;
    endfunction

    vec_t directed [$];

    // Random request: mostly operations on remembered prefixes.
    function automatic lpm_pkg::req_t random_request();
        lpm_pkg::req_t r;
        lpm_pkg::req_t s;
        int            k;
        r.addr_hi = {$urandom, $urandom};
        r.addr_lo = {$urandom, $urandom};
        r.value = $urandom;
        k = $urandom_range(0, 99);
        r.is_v6 = 1'($urandom_range(0, 1));
        if (k < 8)
            r.prefix_len = 8'($urandom_range(0, 255));
        else if (k < 12)
            r.prefix_len = 8'd0;
        else if (r.is_v6)
            r.prefix_len = 8'($urandom_range(1, 128));
        else
            r.prefix_len = 8'($urandom_range(1, 32));
        r.func = lpm_pkg::func_t'(2'($urandom_range(0, 2)));
        if ($urandom_range(0, 15) == 0)
            r.func = lpm_pkg::FUNC_SPARE;
        if (route_pool.size() > 0 && $urandom_range(0, 99) < 60)
        begin
            s = route_pool[$urandom_range(0, route_pool.size() - 1)];
            r.is_v6 = s.is_v6;
            r.addr_hi = s.addr_hi;
            r.addr_lo = s.addr_lo;
            if (r.func == lpm_pkg::FUNC_LOOKUP || r.func == lpm_pkg::FUNC_SPARE)
            begin
                // flip only bits past the stored prefix so longer ones compete
                if (s.prefix_len < 128 && $urandom_range(0, 1))
                    {r.addr_hi, r.addr_lo} = {s.addr_hi, s.addr_lo}
                        ^ (~len_mask(s.prefix_len) & {$urandom, $urandom, $urandom, $urandom});
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                r.prefix_len = s.prefix_len;
            end
        end
        if (r.func == lpm_pkg::FUNC_INSERT && route_pool.size() < 200)
            route_pool.push_back(r);
        return r;
    endfunction

    // Clock and reset
    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: stall on its own pattern, with calm stretches between.
    int stall_mode;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Check each response beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (rsp_pending.size() == 0)
            begin
                $display("%0t unexpected beat: expected none actual %0d/%h", $time,
                         out_data.status, out_data.result_value);
                errors++;
            end
            else
            begin
                lpm_pkg::rsp_t w;
                w = rsp_pending.pop_front();
                if (out_data.status !== w.status)
                begin
                    $display("%0t status: expected %0d actual %0d", $time,
                             w.status, out_data.status);
                    errors++;
                end
                if (out_data.result_value !== w.result_value)
                begin
                    $display("%0t value: expected %h actual %h", $time,
                             w.result_value, out_data.result_value);
                    errors++;
                end
            end
        end
    end

    // Hold a beat until accepted, then drop valid or keep it for the next one.
    task automatic send_beat(input lpm_pkg::req_t r, input logic fixed,
                             input lpm_pkg::rsp_t want, input logic keep_on);
        lpm_pkg::rsp_t p;
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (!in_ready);
        p = route_table_step(r);
        if (fixed && p !== want)
        begin
            $display("%0t directed row: expected %0d/%h actual %0d/%h", $time,
                     want.status, want.result_value, p.status, p.result_value);
            errors++;
        end
        rsp_pending.push_back(p);
        if (!keep_on)
            in_valid <= 1'b0;
    endtask

    initial
    begin
        int burst;
        int gap;
        int n;
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        dflt_valid = 1'b0;
        dflt_val = '0;
        for (int i = 0; i < N_SLOTS; i++)
            rt_valid[i] = 1'b0;

        // empty table, extremes, bad lengths, default route, spare code
        directed.push_back('{mk(lpm_pkg::FUNC_LOOKUP, '1, '1, 1, 8'd0, 0), 1,
                             rs(lpm_pkg::ST_NOT_FOUND, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_REMOVE, '1, '0, 0, 8'd8, 0), 1,
                             rs(lpm_pkg::ST_NOT_FOUND, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_INSERT, '1, '1, 0, 8'd33, 5), 1,
                             rs(lpm_pkg::ST_BAD_LEN, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_REMOVE, '0, '0, 1, 8'd129, 0), 1,
                             rs(lpm_pkg::ST_BAD_LEN, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_INSERT, '0, '0, 1, 8'd255, 1), 1,
                             rs(lpm_pkg::ST_BAD_LEN, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_INSERT, '0, '0, 0, 8'd0, 32'hffffffff), 1,
                             rs(lpm_pkg::ST_OK, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_LOOKUP, 64'h12345678_00000000, '0, 0, 8'd200, 0),
                             1, rs(lpm_pkg::ST_OK, 32'hffffffff)});
        directed.push_back('{mk(lpm_pkg::FUNC_SPARE, '0, '0, 1, 8'd0, 0), 1,
                             rs(lpm_pkg::ST_OK, 32'hffffffff)});
        directed.push_back('{mk(lpm_pkg::FUNC_INSERT, 64'h0A000000_ffffffff, '1, 0, 8'd8,
                                32'h11), 1, rs(lpm_pkg::ST_OK, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_INSERT, 64'h0A010000_00000000, '0, 0, 8'd16,
                                32'h22), 1, rs(lpm_pkg::ST_OK, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_LOOKUP, 64'h0A01FFFF_12345678, '1, 0, 8'd0, 0),
                             0, '0});
        directed.push_back('{mk(lpm_pkg::FUNC_LOOKUP, 64'h0A02FFFF_00000000, '0, 0, 8'd0, 0),
                             0, '0});
        directed.push_back('{mk(lpm_pkg::FUNC_INSERT, 64'h0A0000FF_00000000, '0, 0, 8'd8,
                                32'h33), 1, rs(lpm_pkg::ST_OK, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_INSERT, '1, '1, 1, 8'd128, 32'h44), 1,
                             rs(lpm_pkg::ST_OK, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_INSERT, '1, '1, 0, 8'd32, 32'h55), 1,
                             rs(lpm_pkg::ST_OK, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_LOOKUP, '1, '1, 1, 8'd0, 0), 0, '0});
        directed.push_back('{mk(lpm_pkg::FUNC_LOOKUP, '1, '0, 0, 8'd0, 0), 0, '0});
        directed.push_back('{mk(lpm_pkg::FUNC_INSERT, 64'h80000000_00000000, '0, 1, 8'd1,
                                32'h66), 1, rs(lpm_pkg::ST_OK, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_REMOVE, 64'h0A000000_00000000, '0, 0, 8'd8, 0),
                             1, rs(lpm_pkg::ST_OK, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_REMOVE, '0, '0, 0, 8'd0, 0), 1,
                             rs(lpm_pkg::ST_OK, 0)});
        directed.push_back('{mk(lpm_pkg::FUNC_LOOKUP, 64'h0B000000_00000000, '0, 0, 8'd0, 0),
                             1, rs(lpm_pkg::ST_NOT_FOUND, 0)});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_beat(directed[i].r, directed[i].fixed, directed[i].want, 1'b1);

        // Fill the table to the brim, overflow it, then remove the length-100 routes.
        for (int i = 0; i < N_SLOTS + 2; i++)
            send_beat(mk(lpm_pkg::FUNC_INSERT, {$urandom, $urandom}, {$urandom, $urandom}, 1,
                         8'd100, $urandom), 0, '0, 1'b1);
        for (int i = 0; i < N_SLOTS; i++)
            if (rt_valid[i] && rt_v6[i] && rt_len[i] == 100)
                send_beat(mk(lpm_pkg::FUNC_REMOVE, rt_pfx[i][127:64], rt_pfx[i][63:0], 1,
                             8'd100, 0), 0, '0, 1'b1);

        // Bursty random traffic; valid drops only before a real gap.
        n = 0;
        while (n < N_RANDOM)
        begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
                send_beat(random_request(), 0, '0,
                          (n + 1 < N_RANDOM) && ((b + 1 < burst) || (gap == 0)));
            repeat (gap) @(posedge clk);
        end

        while (rsp_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/lpm_pkg.sv
hw/rtl/lpm_ram.sv
hw/rtl/longest_prefix_match_table_unit.sv
tb/tb_longest_prefix_match_table_unit.sv
